>>> rtl/dip_pkg.sv
// Shared types, constants and helper functions for the icon DIB pixel decoder.
// Depends on nothing; all other files but dip_palette_ram import it.
package dip_pkg;

	// Default values of the top-level parameters.
	localparam int DEF_PALETTE_DEPTH = 256;
	localparam int DEF_MAX_SIDE      = 255;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	// Register reset values.
	localparam logic [2:0] RST_PIXEL_FORMAT  = 3'd2;
	localparam logic [7:0] RST_IMAGE_WIDTH   = 8'd32;
	localparam logic [7:0] RST_IMAGE_HEIGHT  = 8'd32;
	localparam logic [8:0] RST_PALETTE_COUNT = 9'd0;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PIXEL_FORMAT  = 2'd0,
		REG_IMAGE_WIDTH   = 2'd1,
		REG_IMAGE_HEIGHT  = 2'd2,
		REG_PALETTE_COUNT = 2'd3
	} cfg_reg_t;

	// Position inside a frame.
	typedef enum logic [1:0] {
		PH_PAL  = 2'd0,
		PH_PIX  = 2'd1,
		PH_MASK = 2'd2
	} phase_t;

	// Decoded pixel depth.
	typedef enum logic [2:0] {
		BPP1  = 3'd0,
		BPP4  = 3'd1,
		BPP8  = 3'd2,
		BPP24 = 3'd3,
		BPP32 = 3'd4
	} bpp_t;

	// How the result lanes of one byte get their values.
	typedef enum logic [2:0] {
		M_BIT    = 3'd0,
		M_NIB    = 3'd1,
		M_BYTE   = 3'd2,
		M_DIRECT = 3'd3,
		M_MASK   = 3'd4
	} mode_t;

	// Result kinds on the output stream.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// One decoded byte handed from the decoder to the result stage.
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  data;
		logic        ld_a;
		logic        ld_b;
		logic [31:0] direct;
		logic [7:0]  pos_y;
		logic [7:0]  x_base;
		logic [7:0]  lanes;
	} dip_job_t;

	// Format codes five to seven behave as eight bits per pixel.
	function automatic bpp_t bpp_of(input logic [2:0] fmt);
		bpp_t r;
		case (fmt)
			3'd0: r = BPP1;
			3'd1: r = BPP4;
			3'd3: r = BPP24;
			3'd4: r = BPP32;
			default: r = BPP8;
		endcase
		return r;
	endfunction

	// Bytes gathered as first, second, third become third, second, first.
	function automatic logic [23:0] swap_rgb(input logic [23:0] g);
		return {g[7:0], g[15:8], g[23:16]};
	endfunction

endpackage

>>> rtl/dib_icon_pixel_decoder.sv
// Top level of the icon DIB pixel decoder: ports, configuration ready and the
// three parts. Uses dip_pkg, dip_palette_ram, dip_decode and dip_emit.
//
// Usage: the body of an icon bitmap enters one byte per beat on the s_ group:
// palette entries (blue, green, red, reserved), pixel rows bottom first, then
// for formats below 32 bpp the AND-mask rows. Each beat on the m_ group is a
// pixel write (tuser low) or an alpha clear (tuser high) at x, y; tlast marks
// the final result caused by one input byte. The user must write registers on
// the cfg channel, which is always ready, only between frames or while the
// block is idle; the block does not enforce it. Throughput: one byte per cycle
// while m_tready is high and each byte gives at most one result (palette
// bytes, 8, 24 and 32 bpp rows, padding). A byte that gives more results (up
// to 8 for 1 bpp and mask bytes, up to 2 for 4 bpp) holds the input until its
// last is sent, since the result stage sends one lane per cycle while m_tready
// is high. Palette colors sit in a two-read-port memory; reads for the byte are
// issued when it is taken; the result stage uses the registered data. Reset
// clears all counters, loaded flags and both result valid flags; no pass over
// the memory is needed. If m_tready stays low, one result waits in the output
// register, one byte waits in the result stage and s_tready drops.
module dib_icon_pixel_decoder #(
	parameter int PALETTE_DEPTH = dip_pkg::DEF_PALETTE_DEPTH,
	parameter int MAX_SIDE      = dip_pkg::DEF_MAX_SIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dip_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dip_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_byte
	// Output stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,   // [7:0] pos_x, [15:8] pos_y,
	                                                   // [47:16] pixel_value
	output logic                            m_tuser,   // [0] kind
	output logic                            m_tlast
);
	import dip_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);

	dip_job_t    job;
	logic        job_load;
	logic        s1_free;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [23:0] wr_data;
	logic        rd_en;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [23:0] rd_data_a;
	logic [23:0] rd_data_b;
	logic [7:0]  out_x;
	logic [7:0]  out_y;
	logic [31:0] out_value;

	assign cfg_ready = 1'b1;
	assign s_tready  = s1_free;

	// Palette color memory.
	dip_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// Byte decoder and frame state.
	dip_decode #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.MAX_SIDE      (MAX_SIDE),
		.AW            (AW)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.in_ready  (s1_free),
		.job       (job),
		.job_load  (job_load),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	// Result stage and output register.
	dip_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_load  (job_load),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.out_ready (m_tready),
		.s1_free   (s1_free),
		.out_valid (m_tvalid),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_value (out_value),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_value, out_y, out_x};

endmodule

>>> rtl/dip_palette_ram.sv
// Palette color store: one write port and two registered read ports.
// Depends on dip_pkg only through the parameters handed down from the top level.
module dip_palette_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [23:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [23:0]   rd_data_a,
	output logic [23:0]   rd_data_b
);

	logic [23:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Both read ports, data registered and valid in the cycle after the address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

>>> rtl/dip_decode.sv
// Byte decoder: configuration registers, frame counters, palette loading and
// loaded flags, and per-byte result lanes. Uses dip_pkg and drives dip_palette_ram.
module dip_decode #(
	parameter int PALETTE_DEPTH = dip_pkg::DEF_PALETTE_DEPTH,
	parameter int MAX_SIDE      = dip_pkg::DEF_MAX_SIDE,
	parameter int AW            = $clog2(PALETTE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [dip_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dip_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                        in_valid,
	input  logic [7:0]                  in_data,
	input  logic                        in_ready,
	output dip_pkg::dip_job_t           job,
	output logic                        job_load,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [23:0]                 wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr_a,
	output logic [AW-1:0]               rd_addr_b
);
	import dip_pkg::*;

	// Configuration registers.
	logic [2:0] fmt_q;
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [8:0] pcount_q;

	// Frame state.
	phase_t                   phase_q;
	logic [8:0]               entry_q;
	logic [1:0]               big_q;
	logic [9:0]               pos_q;
	logic [8:0]               div3_q;
	logic [1:0]               mod3_q;
	logic [7:0]               rows_q;
	logic [23:0]              gather_q;
	logic [PALETTE_DEPTH-1:0] loaded_q;

	// Decode results.
	logic        accept;
	bpp_t        bpp;
	logic [7:0]  w;
	logic [7:0]  h;
	logic [8:0]  full;
	logic [8:0]  entries;
	logic        pal_take;
	logic        pal_wr;
	phase_t      eff_phase;
	logic [9:0]  eff_pos;
	logic [8:0]  eff_div3;
	logic [1:0]  eff_mod3;
	logic [7:0]  eff_rows;
	logic [23:0] eff_gather;
	logic [13:0] row_bits;
	logic [13:0] row_words;
	logic [9:0]  bpl;
	logic        row_end;
	logic [7:0]  rows_dec;
	logic        frame_end;
	logic [7:0]  idx_a;
	logic [7:0]  idx_b;
	logic [12:0] x_bit;
	logic        direct_hit;

	// Next state.
	phase_t      phase_d;
	logic [8:0]  entry_d;
	logic [1:0]  big_d;
	logic [9:0]  pos_d;
	logic [8:0]  div3_d;
	logic [1:0]  mod3_d;
	logic [7:0]  rows_d;
	logic [23:0] gather_d;

	function automatic logic [7:0] side(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v == 8'd0) begin
			r = 8'd1;
		end
		if (r > 8'(MAX_SIDE)) begin
			r = 8'(MAX_SIDE);
		end
		return r;
	endfunction

	assign accept = in_valid && in_ready;

	// Configuration writes; the port never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= RST_PIXEL_FORMAT;
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			pcount_q <= RST_PALETTE_COUNT;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_PIXEL_FORMAT:  fmt_q    <= cfg_data[2:0];
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[7:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[7:0];
				REG_PALETTE_COUNT: pcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Palette phase bookkeeping and the switch into the pixel rows.
	always_comb begin
		bpp = bpp_of(fmt_q);
		w   = side(width_q);
		h   = side(height_q);
		case (bpp)
			BPP1:    full = 9'd2;
			BPP4:    full = 9'd16;
			BPP8:    full = 9'd256;
			default: full = 9'd0;
		endcase
		entries  = (pcount_q != 9'd0 && pcount_q < full) ? pcount_q : full;
		pal_take = (phase_q == PH_PAL) && (entry_q < entries);
		pal_wr   = pal_take && (big_q == 2'd3) && ({1'b0, entry_q} < 10'(PALETTE_DEPTH));

		if (phase_q == PH_PAL) begin
			eff_phase  = PH_PIX;
			eff_pos    = 10'd0;
			eff_div3   = 9'd0;
			eff_mod3   = 2'd0;
			eff_rows   = h;
			eff_gather = 24'd0;
		end else begin
			eff_phase  = phase_q;
			eff_pos    = pos_q;
			eff_div3   = div3_q;
			eff_mod3   = mod3_q;
			eff_rows   = rows_q;
			eff_gather = gather_q;
		end
	end

	// Row length in bytes, padded to whole 32-bit words.
	always_comb begin
		if (eff_phase == PH_MASK) begin
			row_bits = {6'd0, w};
		end else begin
			case (bpp)
				BPP1:    row_bits = {6'd0, w};
				BPP4:    row_bits = {4'd0, w, 2'd0};
				BPP8:    row_bits = {3'd0, w, 3'd0};
				BPP24:   row_bits = {2'd0, w, 4'd0} + {3'd0, w, 3'd0};
				default: row_bits = {1'b0, w, 5'd0};
			endcase
		end
		row_words = (row_bits + 14'd31) >> 5;
		bpl       = {row_words[7:0], 2'b00};
		row_end   = ({1'b0, eff_pos} + 11'd1) >= {1'b0, bpl};
		rows_dec  = (eff_rows != 8'd0) ? eff_rows - 8'd1 : 8'd0;
		frame_end = !pal_take && row_end && (rows_dec == 8'd0) &&
			!((eff_phase == PH_PIX) && (bpp != BPP32));
	end

	// Result lanes of this byte and the palette reads they need.
	always_comb begin
		job        = '0;
		job.data   = in_data;
		job.pos_y  = rows_dec;
		idx_a      = in_data;
		idx_b      = 8'd0;
		direct_hit = 1'b0;
		x_bit      = 13'd0;
		if (eff_phase == PH_MASK) begin
			job.mode   = M_MASK;
			job.x_base = {eff_pos[4:0], 3'd0};
			for (int i = 0; i < 8; i++) begin
				x_bit        = {eff_pos, 3'd0} + 13'(i);
				job.lanes[i] = (x_bit < {5'd0, w}) && in_data[7-i];
			end
		end else begin
			case (bpp)
				BPP1: begin
					job.mode   = M_BIT;
					job.x_base = {eff_pos[4:0], 3'd0};
					idx_a      = 8'd0;
					idx_b      = 8'd1;
					for (int i = 0; i < 8; i++) begin
						x_bit        = {eff_pos, 3'd0} + 13'(i);
						job.lanes[i] = x_bit < {5'd0, w};
					end
				end
				BPP4: begin
					job.mode     = M_NIB;
					job.x_base   = {eff_pos[6:0], 1'b0};
					idx_a        = {4'd0, in_data[7:4]};
					idx_b        = {4'd0, in_data[3:0]};
					job.lanes[0] = {eff_pos, 1'b0} < {3'd0, w};
					job.lanes[1] = ({eff_pos, 1'b0} + 11'd1) < {3'd0, w};
				end
				BPP8: begin
					job.mode     = M_BYTE;
					job.x_base   = eff_pos[7:0];
					job.lanes[0] = eff_pos < {2'd0, w};
				end
				BPP24: begin
					job.mode     = M_DIRECT;
					job.x_base   = eff_div3[7:0];
					direct_hit   = eff_mod3 == 2'd2;
					job.direct   = {8'hFF, swap_rgb({eff_gather[15:0], in_data})};
					job.lanes[0] = direct_hit && (eff_div3 < {1'b0, w});
				end
				default: begin
					job.mode     = M_DIRECT;
					job.x_base   = eff_pos[9:2];
					direct_hit   = eff_pos[1:0] == 2'd3;
					job.direct   = {in_data, swap_rgb(eff_gather)};
					job.lanes[0] = direct_hit && (eff_pos[9:2] < w);
				end
			endcase
		end
		if (pal_take) begin
			job.lanes = 8'd0;
		end
		job.ld_a = ({1'b0, idx_a} < 9'(PALETTE_DEPTH)) && loaded_q[idx_a[AW-1:0]];
		job.ld_b = ({1'b0, idx_b} < 9'(PALETTE_DEPTH)) && loaded_q[idx_b[AW-1:0]];
	end

	// Next counters and phase.
	always_comb begin
		phase_d  = phase_q;
		entry_d  = entry_q;
		big_d    = big_q;
		pos_d    = pos_q;
		div3_d   = div3_q;
		mod3_d   = mod3_q;
		rows_d   = rows_q;
		gather_d = gather_q;
		if (pal_take) begin
			if (big_q != 2'd3) begin
				gather_d = {gather_q[15:0], in_data};
				big_d    = big_q + 2'd1;
			end else begin
				entry_d  = entry_q + 9'd1;
				big_d    = 2'd0;
				gather_d = 24'd0;
			end
		end else begin
			phase_d = eff_phase;
			rows_d  = eff_rows;
			// Only the wide formats collect bytes of a pixel.
			gather_d = eff_gather;
			if (eff_phase == PH_PIX && (bpp == BPP24 || bpp == BPP32)) begin
				gather_d = direct_hit ? 24'd0 : {eff_gather[15:0], in_data};
			end
			if (row_end) begin
				pos_d    = 10'd0;
				div3_d   = 9'd0;
				mod3_d   = 2'd0;
				gather_d = 24'd0;
				rows_d   = rows_dec;
				if (rows_dec == 8'd0) begin
					if (frame_end) begin
						phase_d = PH_PAL;
						entry_d = 9'd0;
						big_d   = 2'd0;
						rows_d  = 8'd0;
					end else begin
						phase_d = PH_MASK;
						rows_d  = h;
					end
				end
			end else begin
				pos_d  = eff_pos + 10'd1;
				mod3_d = (eff_mod3 == 2'd2) ? 2'd0 : eff_mod3 + 2'd1;
				div3_d = eff_div3 + {8'd0, eff_mod3 == 2'd2};
			end
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PAL;
			entry_q  <= 9'd0;
			big_q    <= 2'd0;
			pos_q    <= 10'd0;
			div3_q   <= 9'd0;
			mod3_q   <= 2'd0;
			rows_q   <= 8'd0;
			gather_q <= 24'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			entry_q  <= entry_d;
			big_q    <= big_d;
			pos_q    <= pos_d;
			div3_q   <= div3_d;
			mod3_q   <= mod3_d;
			rows_q   <= rows_d;
			gather_q <= gather_d;
		end
	end

	// Loaded flags: set per palette entry, all cleared when a frame ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				loaded_q <= '0;
			end else if (pal_wr) begin
				loaded_q[entry_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	// Memory and result stage hookup.
	assign wr_en     = accept && pal_wr;
	assign wr_addr   = entry_q[AW-1:0];
	assign wr_data   = swap_rgb(gather_q);
	assign rd_en     = accept;
	assign rd_addr_a = idx_a[AW-1:0];
	assign rd_addr_b = idx_b[AW-1:0];
	assign job_load  = accept && (job.lanes != 8'd0);

	// Palette colors are written only while the palette is being loaded.
	a_wr_in_palette: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (phase_q == PH_PAL))
		else $error("palette write outside the palette phase");

endmodule

>>> rtl/dip_emit.sv
// Result stage: holds one decoded byte, walks its lanes one per cycle when the
// output register is free and feeds it. Uses dip_pkg and the palette read data.
module dip_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  dip_pkg::dip_job_t job,
	input  logic              job_load,
	input  logic [23:0]       rd_data_a,
	input  logic [23:0]       rd_data_b,
	input  logic              out_ready,
	output logic              s1_free,
	output logic              out_valid,
	output logic [7:0]        out_x,
	output logic [7:0]        out_y,
	output logic [31:0]       out_value,
	output logic              out_kind,
	output logic              out_last
);
	import dip_pkg::*;

	dip_job_t    job_s1;
	logic        valid_s1;
	logic [7:0]  lanes_s1;

	logic        out_valid_q;
	logic [7:0]  out_x_q;
	logic [7:0]  out_y_q;
	logic [31:0] out_value_q;
	logic        out_kind_q;
	logic        out_last_q;

	logic [7:0]  lane_oh;
	logic [2:0]  lane;
	logic [7:0]  rest;
	logic        is_last;
	logic        out_free;
	logic        take;
	logic        sel_b;
	logic [31:0] pal_a;
	logic [31:0] pal_b;
	logic [31:0] value;
	logic        kind;

	// Lowest pending lane goes next.
	always_comb begin
		lane_oh = lanes_s1 & (~lanes_s1 + 8'd1);
		lane    = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (lane_oh[i]) begin
				lane = 3'(i);
			end
		end
		rest     = lanes_s1 & ~lane_oh;
		is_last  = rest == 8'd0;
		out_free = !out_valid_q || out_ready;
		take     = valid_s1 && out_free;
		s1_free  = !valid_s1 || (take && is_last);
	end

	// Value of the selected lane.
	always_comb begin
		pal_a = job_s1.ld_a ? {8'hFF, rd_data_a} : 32'd0;
		pal_b = job_s1.ld_b ? {8'hFF, rd_data_b} : 32'd0;
		sel_b = 1'b0;
		kind  = KIND_WRITE;
		case (job_s1.mode)
			M_BIT:    sel_b = job_s1.data[3'd7 - lane];
			M_NIB:    sel_b = lane[0];
			default:  sel_b = 1'b0;
		endcase
		case (job_s1.mode)
			M_DIRECT: value = job_s1.direct;
			M_MASK: begin
				value = 32'd0;
				kind  = KIND_CLEAR;
			end
			default:  value = sel_b ? pal_b : pal_a;
		endcase
	end

	// Held byte and its pending lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			lanes_s1 <= 8'd0;
		end else if (job_load) begin
			valid_s1 <= 1'b1;
			lanes_s1 <= job.lanes;
		end else if (take) begin
			valid_s1 <= !is_last;
			lanes_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_s1 <= job;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_x_q     <= job_s1.x_base + {5'd0, lane};
			out_y_q     <= job_s1.pos_y;
			out_value_q <= value;
			out_kind_q  <= kind;
			out_last_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_value = out_value_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	// A held byte always has a lane left to send.
	a_lanes_pending: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (lanes_s1 != 8'd0))
		else $error("held byte with no pending lane");

	// Sending the final lane with nothing new frees the stage.
	a_frees_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_last && !job_load) |=> !valid_s1)
		else $error("stage still busy after its final lane");

	// A new byte is loaded only into a free stage.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(take && is_last)) |-> !job_load)
		else $error("byte loaded over a busy stage");

endmodule

>>> sim/dib_icon_pixel_decoder_tb.sv
// Self-checking testbench for the icon DIB pixel decoder.
// Streams palette, pixel and mask bytes into the block, predicts every pixel write and
// alpha clear in its own decoder model, and compares the output beats. Needs dip_pkg.
module dib_icon_pixel_decoder_tb;
	import dip_pkg::*;

	localparam int PAL_SLOTS     = DEF_PALETTE_DEPTH;
	localparam int SIDE_MAX      = DEF_MAX_SIDE;
	localparam int RANDOM_BYTES  = 260;
	localparam int SETTLE_CYCLES = 6;

	// One output beat: a pixel write or an alpha clear.
	typedef struct packed {
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [31:0] argb;
		logic        kind;
		logic        last;
	} pix_result_t;

	typedef struct packed {
		cfg_reg_t   idx;
		logic [8:0] value;
	} cfg_write_t;

	typedef enum logic {ROW_REG, ROW_BYTE} row_kind_t;

	// One line of the directed sequence; want is used only when typed is set.
	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    idx;
		logic [8:0]  value;
		logic        typed;
		pix_result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;   // [7:0] pos_x, [15:8] pos_y, [47:16] pixel_value
	logic        m_tuser;   // [0] kind
	logic        m_tlast;

	// Decoder model: configuration and frame state.
	logic [2:0]  cfg_fmt;
	logic [7:0]  cfg_width;
	logic [7:0]  cfg_height;
	logic [8:0]  cfg_count;
	phase_t      ph;
	logic [23:0] pal_rgb [PAL_SLOTS];
	bit          pal_loaded [PAL_SLOTS];
	logic [8:0]  entry_idx;
	logic [1:0]  grp_byte;
	logic [9:0]  row_pos;
	logic [7:0]  rows_left;
	logic [23:0] gather;
	bit          frame_closed;

	pix_result_t due_pixels [$];
	cfg_write_t  cfg_pending [$];
	plan_row_t   plan [$];

	int fail_count = 0;
	int sent_count = 0;
	int feed_calm = 0;
	int ready_calm = 0;
	int ready_hold = 0;
	int ready_pick;
	int byte_goal;
	pix_result_t seen, want;

	dib_icon_pixel_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Global run limit, far above the slowest legal run.
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int depth_bits(logic [2:0] fmt);
		case (fmt)
			BPP1:    return 1;
			BPP4:    return 4;
			BPP24:   return 24;
			BPP32:   return 32;
			default: return 8;
		endcase
	endfunction

	// A side of zero counts as one pixel, and one above SIDE_MAX as SIDE_MAX.
	function automatic int side_len(logic [7:0] v);
		if (v == 0) return 1;
		if (v > SIDE_MAX) return SIDE_MAX;
		return v;
	endfunction

	function automatic logic [31:0] palette_argb(int idx);
		if (idx >= PAL_SLOTS || !pal_loaded[idx]) return 32'h0;
		return {8'hFF, pal_rgb[idx]};
	endfunction

	function automatic void push_pixel(int x, int y, logic [31:0] argb, logic k);
		pix_result_t p;
		p.pos_x = x[7:0];
		p.pos_y = y[7:0];
		p.argb = argb;
		p.kind = k;
		p.last = 1'b0;
		due_pixels = {due_pixels, p};
	endfunction

	// End of frame: back to the palette phase with every entry forgotten.
	function automatic void start_frame();
		ph = PH_PAL;
		foreach (pal_loaded[i]) pal_loaded[i] = 1'b0;
		entry_idx = '0;
		grp_byte = '0;
		row_pos = '0;
		rows_left = '0;
		gather = '0;
		frame_closed = 1'b1;
	endfunction

	// Works out the results of one accepted byte and queues them.
	function automatic void decode_byte(logic [7:0] b);
		int bpp, w, entries, full, yy, pos, bpl, grp, xx, base;
		logic [23:0] g3;
		logic [7:0]  alpha;
		bpp = depth_bits(cfg_fmt);
		w = side_len(cfg_width);
		base = due_pixels.size();

		// Palette bytes gather blue, green, red; the fourth byte stores the entry.
		if (ph == PH_PAL) begin
			entries = 0;
			if (bpp <= 8) begin
				full = 1 << bpp;
				entries = (cfg_count != 0 && cfg_count < full) ? int'(cfg_count) : full;
			end
			if (entry_idx < entries) begin
				if (grp_byte < 3) begin
					gather = {gather[15:0], b};
					grp_byte++;
				end else begin
					if (entry_idx < PAL_SLOTS) begin
						pal_rgb[entry_idx] = {gather[7:0], gather[15:8], gather[23:16]};
						pal_loaded[entry_idx] = 1'b1;
					end
					entry_idx++;
					grp_byte = '0;
					gather = '0;
				end
				return;
			end
			ph = PH_PIX;
			rows_left = 8'(side_len(cfg_height));
			row_pos = '0;
			gather = '0;
		end

		yy = (rows_left != 0) ? rows_left - 1 : 0;
		pos = row_pos;
		if (ph == PH_PIX) begin
			bpl = (w * bpp + 31) / 32 * 4;
			case (bpp)
				1: begin
					for (int i = 0; i < 8; i++) begin
						xx = pos * 8 + i;
						if (xx < w) push_pixel(xx, yy, palette_argb(b[7 - i]), KIND_WRITE);
					end
				end
				4: begin
					if (pos * 2 < w) push_pixel(pos * 2, yy, palette_argb(b[7:4]), KIND_WRITE);
					if (pos * 2 + 1 < w)
						push_pixel(pos * 2 + 1, yy, palette_argb(b[3:0]), KIND_WRITE);
				end
				8: begin
					if (pos < w) push_pixel(pos, yy, palette_argb(b), KIND_WRITE);
				end
				default: begin
					// Direct color: the pixel leaves on its last byte.
					grp = bpp / 8;
					if (pos % grp == grp - 1) begin
						g3 = (grp == 3) ? {gather[15:0], b} : gather;
						alpha = (grp == 4) ? b : 8'hFF;
						if (pos / grp < w)
							push_pixel(pos / grp, yy,
								{alpha, g3[7:0], g3[15:8], g3[23:16]}, KIND_WRITE);
						gather = '0;
					end else begin
						gather = {gather[15:0], b};
					end
				end
			endcase
		end else begin
			bpl = (w + 31) / 32 * 4;
			for (int i = 0; i < 8; i++) begin
				xx = pos * 8 + i;
				if (xx < w && b[7 - i]) push_pixel(xx, yy, 32'h0, KIND_CLEAR);
			end
		end

		// Row and plane bookkeeping against the current row length.
		if (pos + 1 >= bpl) begin
			row_pos = '0;
			gather = '0;
			if (rows_left != 0) rows_left--;
			if (rows_left == 0) begin
				if (ph == PH_PIX && bpp < 32) begin
					ph = PH_MASK;
					rows_left = 8'(side_len(cfg_height));
				end else begin
					start_frame();
				end
			end
		end else begin
			row_pos = 10'(pos + 1);
		end

		if (due_pixels.size() > base) due_pixels[due_pixels.size() - 1].last = 1'b1;
	endfunction

	function automatic void queue_reg(cfg_reg_t idx, logic [8:0] value);
		cfg_write_t cw;
		cw.idx = idx;
		cw.value = value;
		cfg_pending = {cfg_pending, cw};
	endfunction

	function automatic plan_row_t reg_row(cfg_reg_t idx, logic [8:0] value);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.value = value;
		return row;
	endfunction

	function automatic plan_row_t byte_row(logic [7:0] b);
		plan_row_t row;
		row = '0;
		row.kind = ROW_BYTE;
		row.value = {1'b0, b};
		return row;
	endfunction

	// A byte whose single result is written out by hand.
	function automatic plan_row_t checked_row(logic [7:0] b, logic [7:0] x, logic [7:0] y,
		logic [31:0] argb, logic k);
		plan_row_t row;
		row = byte_row(b);
		row.typed = 1'b1;
		row.want = '{pos_x: x, pos_y: y, argb: argb, kind: k, last: 1'b1};
		return row;
	endfunction

	// Mostly back-to-back beats, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		if (feed_calm > 0) begin
			feed_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) feed_calm = $urandom_range(10, 60);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic logic [7:0] frame_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bit first_faults();
		fail_count++;
		return fail_count <= 10;
	endfunction

	// Sends one byte; valid stays high afterwards until the next call or a pause.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		sent_count++;
	endtask

	// Waits until the block is idle, then writes every queued register.
	task automatic flush_regs();
		cfg_write_t cw;
		s_tvalid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (cfg_pending.size() != 0) begin
			cw = cfg_pending.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= cw.idx;
			cfg_data <= cw.value;
			do @(posedge clk); while (!cfg_ready);
			case (cw.idx)
				REG_PIXEL_FORMAT:  cfg_fmt = cw.value[2:0];
				REG_IMAGE_WIDTH:   cfg_width = cw.value[7:0];
				REG_IMAGE_HEIGHT:  cfg_height = cw.value[7:0];
				REG_PALETTE_COUNT: cfg_count = cw.value;
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Random frame settings; large widths only where rows stay short.
	task automatic program_frame();
		logic [2:0] fmt;
		logic [7:0] w, h;
		logic [8:0] cnt;
		int bpp, r, sel;
		fmt = 3'($urandom_range(0, 7));
		bpp = depth_bits(fmt);
		r = $urandom_range(0, 99);
		if (r < 8 && bpp <= 4) begin
			w = 8'd255;
			h = 8'($urandom_range(1, 2));
		end else begin
			w = (r < 14) ? 8'd0 : 8'($urandom_range(1, 12));
			h = (r > 90) ? 8'd0 : 8'($urandom_range(1, 5));
		end
		sel = $urandom_range(0, 2);
		if (bpp < 8)
			cnt = (sel == 0) ? 9'd0 : (sel == 1) ? 9'($urandom_range(1, 1 << bpp))
				: 9'($urandom_range(0, 511));
		else if (bpp == 8)
			cnt = 9'($urandom_range(1, 12));
		else
			cnt = 9'($urandom_range(0, 511));
		queue_reg(REG_PIXEL_FORMAT, {6'($urandom_range(0, 63)), fmt});
		queue_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), w});
		queue_reg(REG_IMAGE_HEIGHT, {1'($urandom_range(0, 1)), h});
		queue_reg(REG_PALETTE_COUNT, cnt);
		flush_regs();
	endtask

	// Streams one whole frame; now and then a register changes mid-frame.
	task automatic run_frame();
		cfg_reg_t idx;
		frame_closed = 1'b0;
		while (!frame_closed) begin
			if (ph != PH_PAL && $urandom_range(0, 149) == 0) begin
				idx = cfg_reg_t'($urandom_range(0, 3));
				case (idx)
					REG_PIXEL_FORMAT:  queue_reg(idx, 9'($urandom_range(0, 7)));
					REG_IMAGE_WIDTH:   queue_reg(idx, 9'($urandom_range(0, 16)));
					REG_IMAGE_HEIGHT:  queue_reg(idx, 9'($urandom_range(0, 4)));
					default:           queue_reg(idx, 9'($urandom_range(0, 511)));
				endcase
				flush_regs();
			end
			send_byte(frame_byte());
		end
	endtask

	// Output side: random stalls with calm stretches of constant ready.
	always @(posedge clk) begin
		if (ready_calm > 0) begin
			ready_calm--;
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 3) ready_calm = $urandom_range(20, 100);
			if (ready_pick < 70) begin
				m_tready <= 1'b1;
			end else begin
				ready_hold = (ready_pick < 94) ? $urandom_range(0, 2) : $urandom_range(5, 12);
				m_tready <= 1'b0;
			end
		end
	end

	// Each output beat is matched against the oldest predicted result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = '{pos_x: m_tdata[7:0], pos_y: m_tdata[15:8], argb: m_tdata[47:16],
				kind: m_tuser, last: m_tlast};
			if (due_pixels.size() == 0) begin
				if (first_faults())
					$display("unexpected beat at %0t: x=%0d y=%0d argb=%h kind=%0d last=%0d",
						$time, seen.pos_x, seen.pos_y, seen.argb, seen.kind, seen.last);
			end else begin
				want = due_pixels.pop_front();
				if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
					seen.argb !== want.argb || seen.kind !== want.kind ||
					seen.last !== want.last) begin
					if (first_faults())
						$display({"mismatch at %0t: got x=%0d y=%0d argb=%h kind=%0d last=%0d,",
							" want x=%0d y=%0d argb=%h kind=%0d last=%0d"}, $time,
							seen.pos_x, seen.pos_y, seen.argb, seen.kind, seen.last,
							want.pos_x, want.pos_y, want.argb, want.kind, want.last);
				end
			end
		end
	end

	initial begin
		cfg_fmt = RST_PIXEL_FORMAT;
		cfg_width = RST_IMAGE_WIDTH;
		cfg_height = RST_IMAGE_HEIGHT;
		cfg_count = RST_PALETTE_COUNT;
		foreach (pal_rgb[i]) pal_rgb[i] = '0;
		start_frame();

		// Directed frames: 24 bpp, 32 bpp, then 8 bpp with a one-entry palette.
		plan = '{
			reg_row(REG_PIXEL_FORMAT, 9'd3), reg_row(REG_IMAGE_WIDTH, 9'd1),
			reg_row(REG_IMAGE_HEIGHT, 9'd1), reg_row(REG_PALETTE_COUNT, 9'd0),
			byte_row(8'h11), byte_row(8'h22),
			checked_row(8'h33, 8'd0, 8'd0, 32'hFF332211, KIND_WRITE),
			byte_row(8'h00),
			checked_row(8'h80, 8'd0, 8'd0, 32'h0, KIND_CLEAR),
			byte_row(8'h7F), byte_row(8'hFF), byte_row(8'hFF),
			reg_row(REG_PIXEL_FORMAT, 9'd4),
			byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF),
			checked_row(8'h00, 8'd0, 8'd0, 32'h00FFFFFF, KIND_WRITE),
			reg_row(REG_PIXEL_FORMAT, 9'd7), reg_row(REG_IMAGE_WIDTH, 9'd0),
			reg_row(REG_PALETTE_COUNT, 9'd1),
			byte_row(8'h01), byte_row(8'h02), byte_row(8'h03), byte_row(8'hAA),
			checked_row(8'h00, 8'd0, 8'd0, 32'hFF030201, KIND_WRITE),
			byte_row(8'hFF), byte_row(8'h80), byte_row(8'h01),
			checked_row(8'h80, 8'd0, 8'd0, 32'h0, KIND_CLEAR),
			byte_row(8'h40), byte_row(8'h00), byte_row(8'hFF)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows; consecutive register rows go out as one burst.
		foreach (plan[k]) begin
			if (plan[k].kind == ROW_REG) begin
				queue_reg(plan[k].idx, plan[k].value);
				if (k + 1 == plan.size() || plan[k + 1].kind != ROW_REG) flush_regs();
			end else begin
				send_byte(plan[k].value[7:0]);
				if (plan[k].typed) begin
					void'(due_pixels.pop_back());
					due_pixels = {due_pixels, plan[k].want};
				end
			end
		end

		// A tall image at 32 bpp, then the widest at 1 bpp with an oversized count.
		queue_reg(REG_PIXEL_FORMAT, {6'd0, 3'(BPP32)});
		queue_reg(REG_IMAGE_WIDTH, 9'd1);
		queue_reg(REG_IMAGE_HEIGHT, 9'd24);
		queue_reg(REG_PALETTE_COUNT, 9'd0);
		flush_regs();
		run_frame();
		queue_reg(REG_PIXEL_FORMAT, {6'd0, 3'(BPP1)});
		queue_reg(REG_IMAGE_WIDTH, 9'd255);
		queue_reg(REG_IMAGE_HEIGHT, 9'd1);
		queue_reg(REG_PALETTE_COUNT, 9'd511);
		flush_regs();
		run_frame();

		// Random frames with random content.
		byte_goal = sent_count + RANDOM_BYTES;
		while (sent_count < byte_goal) begin
			program_frame();
			run_frame();
		end

		s_tvalid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES + 4) @(posedge clk);
		if (due_pixels.size() != 0 && first_faults())
			$display("%0d predicted results never arrived", due_pixels.size());
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/dip_pkg.sv
rtl/dip_palette_ram.sv
rtl/dip_decode.sv
rtl/dip_emit.sv
rtl/dib_icon_pixel_decoder.sv
sim/dib_icon_pixel_decoder_tb.sv
